@@ rtl/core/tspwf_pkg.sv @@
// Shared types and constants of the trapezoid speed profiler.
package tspwf_pkg;

  typedef enum logic [1:0] {
    MODE_STRAIGHT = 2'd0,
    MODE_RIGHT    = 2'd1,
    MODE_LEFT     = 2'd2,
    MODE_NONE     = 2'd3
  } run_mode_e;

  typedef enum logic [2:0] {
    REG_SPEED_CEIL   = 3'd0,
    REG_SPEED_FLOOR  = 3'd1,
    REG_FINISH_SPEED = 3'd2,
    REG_REF_RIGHT    = 3'd3,
    REG_REF_LEFT     = 3'd4,
    REG_THRESH_RIGHT = 3'd5,
    REG_THRESH_LEFT  = 3'd6,
    REG_WALL_GAIN    = 3'd7
  } reg_idx_e;

  localparam logic [15:0] SpeedStep = 16'd983;

  localparam int AngW = 25;

  // floor(m*500/47) == (m*RecipMul) >> RecipShift for every m below 2^MagW
  localparam int MagW       = 21;
  localparam int RecipW     = 31;
  localparam int RecipShift = 27;
  localparam int QuotW      = 24;
  localparam logic [RecipW-1:0] RecipMul = 31'd1427848171;

  // smallest |vr-vl| whose scaled value no longer fits the angular range
  localparam logic [MagW-1:0] SatMag = 21'd1577059;

  typedef struct packed {
    logic            neg;
    logic            sat;
    logic            half;
    logic [MagW-1:0] mag;
  } ang_ctrl_t;

endpackage

@@ rtl/core/tspwf_ang_scale.sv @@
// Angular rate scaling: magnitude times 500/47 (or 250/47), sign and saturation.
module tspwf_ang_scale (
  input  tspwf_pkg::ang_ctrl_t              ctrl_i,
  output logic [tspwf_pkg::AngW-1:0]        ang_o
);
  import tspwf_pkg::*;

  logic [MagW+RecipW-1:0] prod;
  logic [QuotW-1:0]       quot;
  logic [QuotW-1:0]       quot_sel;
  logic [AngW-1:0]        mag_ext;

  always_comb begin
    prod     = (MagW+RecipW)'(ctrl_i.mag) * (MagW+RecipW)'(RecipMul);
    quot     = prod[RecipShift +: QuotW];
    // turns use 250/47, i.e. half the straight-run quotient
    quot_sel = ctrl_i.half ? (quot >> 1) : quot;
    mag_ext  = {1'b0, quot_sel};
    if (ctrl_i.sat) begin
      ang_o = ctrl_i.neg ? {1'b1, {(AngW-1){1'b0}}} : {1'b0, {(AngW-1){1'b1}}};
    end else begin
      ang_o = ctrl_i.neg ? (~mag_ext + AngW'(1)) : mag_ext;
    end
  end

endmodule

@@ rtl/core/trapezoid_speed_profile_wall_follow_core.sv @@
// Top level of the trapezoid speed profiler with wall-following steering.
//
//  channel  direction  handshake                  payload
//  in       sink       in_valid_i / in_stall_o    kind, target_length, mode, travelled,
//                                                 sensor_right, sensor_left
//  out      source     out_valid_o / out_stall_i  linear_velocity, angular_velocity,
//                                                 finished, travelled_echo
//  cfg      slave      psel/penable/pwrite/pready 8 registers, 4-byte stride
//
// One item per cycle while the output is not stalled. A tick goes from the input register
// through the profile/state stage into the mid register, then through angular scaling into
// the output register. The state loop is the speed update, v^2 multiply and braking compare.
// Commands update state and give no result. Reset clears all state and loads the
// register defaults. A stalled result holds the whole pipeline and stalls the input.
module trapezoid_speed_profile_wall_follow_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [23:0] target_length_i,
  input  logic [1:0]  mode_i,
  input  logic [23:0] travelled_i,
  input  logic [11:0] sensor_right_i,
  input  logic [11:0] sensor_left_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] linear_velocity_o,
  output logic [tspwf_pkg::AngW-1:0] angular_velocity_o,
  output logic        finished_o,
  output logic [23:0] travelled_echo_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tspwf_pkg::*;

  // configuration registers
  logic [15:0] speed_ceil_q, speed_floor_q, finish_speed_q;
  logic [11:0] ref_right_q, ref_left_q, thresh_right_q, thresh_left_q;
  logic [9:0]  wall_gain_q;
  logic [31:0] fin_sq_q, min_sq_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  // profile state
  logic        running_q, running_d;
  run_mode_e   run_mode_q, run_mode_d;
  logic        decel_q, decel_d;
  logic [15:0] speed_q, speed_d;
  logic [23:0] goal_q, goal_d;

  // pipeline
  logic        en;
  logic        in_v_q, mid_v_q, out_v_q;
  logic        in_kind_q;
  logic [23:0] in_tgt_q, in_trav_q;
  logic [1:0]  in_mode_q;
  logic signed [23:0] in_om_q;

  logic [15:0] mid_lin_q, mid_lin_d;
  ang_ctrl_t   mid_ctrl_q, mid_ctrl_d;
  logic        mid_fin_q, mid_fin_d;
  logic [23:0] mid_trav_q;

  logic [15:0]     out_lin_q;
  logic [AngW-1:0] out_ang_q, ang_scaled;
  logic            out_fin_q;
  logic [23:0]     out_trav_q;

  // wall error path, ahead of the input register
  logic signed [12:0] err_r, err_l;
  logic signed [13:0] err_sum;
  logic signed [23:0] om_prod;

  // state stage intermediates
  logic [15:0]        spd_dec, spd_cl, spd_new;
  logic [16:0]        spd_acc, spd_pre;
  logic [31:0]        vsq, vend_sq;
  logic signed [24:0] rem;
  logic signed [26:0] rem27, rem3;
  logic signed [42:0] brake_lhs, brake_rhs;
  logic signed [32:0] rhs33;
  logic               brake, trav_past;
  logic signed [24:0] vr, vl, vr_f, vl_f, min_s;
  logic signed [25:0] vsum, vdiff;
  logic [25:0]        vmag;

  assign pready = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_SPEED_CEIL:   prdata = {16'h0, speed_ceil_q};
      REG_SPEED_FLOOR:  prdata = {16'h0, speed_floor_q};
      REG_FINISH_SPEED: prdata = {16'h0, finish_speed_q};
      REG_REF_RIGHT:    prdata = {20'h0, ref_right_q};
      REG_REF_LEFT:     prdata = {20'h0, ref_left_q};
      REG_THRESH_RIGHT: prdata = {20'h0, thresh_right_q};
      REG_THRESH_LEFT:  prdata = {20'h0, thresh_left_q};
      REG_WALL_GAIN:    prdata = {22'h0, wall_gain_q};
      default:          prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_ceil_q   <= 16'd22938;
      speed_floor_q  <= 16'd2621;
      finish_speed_q <= 16'd0;
      ref_right_q    <= 12'd1180;
      ref_left_q     <= 12'd570;
      thresh_right_q <= 12'd300;
      thresh_left_q  <= 12'd200;
      wall_gain_q    <= 10'd131;
      fin_sq_q       <= 32'd0;
      min_sq_q       <= 32'd6869641;
    end else begin
      // end-speed squares are kept ready for the braking test
      fin_sq_q <= 32'(finish_speed_q) * 32'(finish_speed_q);
      min_sq_q <= 32'(speed_floor_q) * 32'(speed_floor_q);
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_SPEED_CEIL:   speed_ceil_q   <= pwdata[15:0];
          REG_SPEED_FLOOR:  speed_floor_q  <= pwdata[15:0];
          REG_FINISH_SPEED: finish_speed_q <= pwdata[15:0];
          REG_REF_RIGHT:    ref_right_q    <= pwdata[11:0];
          REG_REF_LEFT:     ref_left_q     <= pwdata[11:0];
          REG_THRESH_RIGHT: thresh_right_q <= pwdata[11:0];
          REG_THRESH_LEFT:  thresh_left_q  <= pwdata[11:0];
          REG_WALL_GAIN:    wall_gain_q    <= pwdata[9:0];
          default: ;
        endcase
      end
    end
  end

  // the whole pipeline moves unless a valid result in the output register is held up
  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  always_comb begin
    err_r = (sensor_right_i > thresh_right_q) ?
            ($signed({1'b0, ref_right_q}) - $signed({1'b0, sensor_right_i})) : 13'sd0;
    err_l = (sensor_left_i > thresh_left_q) ?
            ($signed({1'b0, sensor_left_i}) - $signed({1'b0, ref_left_q})) : 13'sd0;
    err_sum = 14'(err_r) + 14'(err_l);
    om_prod = 24'($signed({1'b0, wall_gain_q})) * 24'(err_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      mid_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      in_v_q  <= in_valid_i;
      mid_v_q <= in_v_q && !in_kind_q;
      out_v_q <= mid_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_kind_q  <= kind_i;
      in_tgt_q   <= target_length_i;
      in_mode_q  <= mode_i;
      in_trav_q  <= travelled_i;
      in_om_q    <= om_prod;
      mid_lin_q  <= mid_lin_d;
      mid_ctrl_q <= mid_ctrl_d;
      mid_fin_q  <= mid_fin_d;
      mid_trav_q <= in_trav_q;
      out_lin_q  <= mid_lin_q;
      out_ang_q  <= ang_scaled;
      out_fin_q  <= mid_fin_q;
      out_trav_q <= mid_trav_q;
    end
  end

  // profile and steering for the item in the input register
  always_comb begin
    running_d  = running_q;
    run_mode_d = run_mode_q;
    decel_d    = decel_q;
    speed_d    = speed_q;
    goal_d     = goal_q;
    mid_lin_d  = 16'd0;
    mid_ctrl_d = '0;
    mid_fin_d  = 1'b0;

    spd_dec = (speed_q > SpeedStep) ? (speed_q - SpeedStep) : 16'd0;
    if (spd_dec < speed_floor_q) spd_dec = speed_floor_q;
    spd_acc = {1'b0, speed_q} + {1'b0, SpeedStep};
    spd_pre = decel_q ? {1'b0, spd_dec} : spd_acc;
    spd_cl  = (spd_pre > {1'b0, speed_ceil_q}) ? speed_ceil_q : spd_pre[15:0];

    vsq     = 32'(spd_cl) * 32'(spd_cl);
    vend_sq = (run_mode_q == MODE_STRAIGHT) ? fin_sq_q : min_sq_q;
    rem     = $signed({1'b0, goal_q}) - $signed({1'b0, in_trav_q});
    rem27   = 27'(rem);
    rem3    = rem27 + (rem27 <<< 1);
    brake_lhs = $signed({rem3, 16'h0});
    rhs33     = $signed({1'b0, vsq}) - $signed({1'b0, vend_sq});
    brake_rhs = 43'(rhs33);
    brake     = brake_lhs < brake_rhs;
    trav_past = in_trav_q > goal_q;

    spd_new = spd_cl;
    if (decel_q && trav_past) spd_new = 16'd0;

    min_s = $signed({9'b0, speed_floor_q});
    vr    = $signed({9'b0, spd_new}) + 25'(in_om_q);
    vl    = $signed({9'b0, spd_new}) - 25'(in_om_q);
    vr_f  = (vr < min_s) ? min_s : vr;
    vl_f  = (vl < min_s) ? min_s : vl;
    vsum  = 26'(vr_f) + 26'(vl_f);
    vdiff = 26'(vr_f) - 26'(vl_f);
    vmag  = vdiff[25] ? 26'(-vdiff) : 26'(vdiff);

    if (in_v_q && en) begin
      if (in_kind_q) begin
        goal_d    = in_tgt_q;
        if (run_mode_e'(in_mode_q) != MODE_NONE) run_mode_d = run_mode_e'(in_mode_q);
        decel_d   = 1'b0;
        running_d = 1'b1;
      end else if (!running_q) begin
        mid_fin_d = 1'b1;
      end else if (run_mode_q == MODE_NONE) begin
        // a run with no mode holds still and never ends by itself
        speed_d = 16'd0;
      end else begin
        speed_d = spd_new;
        if (!decel_q) begin
          if (brake) decel_d = 1'b1;
        end else if (trav_past) begin
          running_d = 1'b0;
        end
        if (run_mode_q == MODE_STRAIGHT) begin
          mid_lin_d       = (vsum[25:17] != 9'd0) ? 16'hFFFF : vsum[16:1];
          mid_ctrl_d.neg  = vdiff[25];
          mid_ctrl_d.sat  = vmag >= 26'(SatMag);
          mid_ctrl_d.half = 1'b0;
          mid_ctrl_d.mag  = vmag[MagW-1:0];
        end else begin
          mid_ctrl_d.neg  = (run_mode_q == MODE_RIGHT);
          mid_ctrl_d.sat  = 1'b0;
          mid_ctrl_d.half = 1'b1;
          mid_ctrl_d.mag  = MagW'(spd_new);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b0;
      run_mode_q <= MODE_NONE;
      decel_q    <= 1'b0;
      speed_q    <= 16'd0;
      goal_q     <= 24'd0;
    end else begin
      running_q  <= running_d;
      run_mode_q <= run_mode_d;
      decel_q    <= decel_d;
      speed_q    <= speed_d;
      goal_q     <= goal_d;
    end
  end

  tspwf_ang_scale u_ang_scale (
    .ctrl_i (mid_ctrl_q),
    .ang_o  (ang_scaled)
  );

  assign out_valid_o        = out_v_q;
  assign linear_velocity_o  = out_lin_q;
  assign angular_velocity_o = out_ang_q;
  assign finished_o         = out_fin_q;
  assign travelled_echo_o   = out_trav_q;

endmodule

@@ sim/tb_top.sv @@
// Self-checking bench for the trapezoid speed profiler: random runs, wall steering, APB setup.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tspwf_pkg::*;

  localparam int SpeedInc = 983;
  localparam longint AngHi = 64'sd16777215;
  localparam longint AngLo = -64'sd16777216;

  typedef struct {
    logic        kind;
    logic [23:0] target;
    run_mode_e   mode;
    logic [23:0] trav;
    logic [11:0] sr;
    logic [11:0] sl;
  } tick_t;

  typedef struct {
    logic [15:0]     lin;
    logic [AngW-1:0] ang;
    logic            fin;
    logic [23:0]     trav;
  } vel_t;

  // predicted profiler state plus the wheel commands still owed by the block
  class wheel_cmd_board;
    int        speed_ceil, speed_floor, finish_speed;
    int        ref_right, ref_left, thresh_right, thresh_left, wall_gain;
    bit        running, braking;
    run_mode_e mode;
    int        speed, goal;
    vel_t      due_velocities[$];
    int        faults;

    function new();
      speed_ceil = 22938; speed_floor = 2621; finish_speed = 0;
      ref_right = 1180; ref_left = 570; thresh_right = 300; thresh_left = 200;
      wall_gain = 131;
      running = 1'b0; braking = 1'b0; mode = MODE_NONE; speed = 0; goal = 0;
      faults = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] val);
      case (idx)
        REG_SPEED_CEIL:   speed_ceil = int'(val[15:0]);
        REG_SPEED_FLOOR:  speed_floor = int'(val[15:0]);
        REG_FINISH_SPEED: finish_speed = int'(val[15:0]);
        REG_REF_RIGHT:    ref_right = int'(val[11:0]);
        REG_REF_LEFT:     ref_left = int'(val[11:0]);
        REG_THRESH_RIGHT: thresh_right = int'(val[11:0]);
        REG_THRESH_LEFT:  thresh_left = int'(val[11:0]);
        REG_WALL_GAIN:    wall_gain = int'(val[9:0]);
        default: ;
      endcase
    endfunction

    function void take_item(tick_t it);
      longint s, vend, trav, sr, sl, er, el, om, vr, vl, lin, ang;
      vel_t   r;
      if (it.kind) begin
        goal = int'(it.target);
        if (it.mode != MODE_NONE) mode = it.mode;
        braking = 1'b0;
        running = 1'b1;
        return;
      end
      trav = longint'(it.trav); sr = longint'(it.sr); sl = longint'(it.sl);
      lin = 0; ang = 0;
      r.fin = !running;
      if (running) begin
        if (braking) begin
          s = speed - SpeedInc;
          if (s < speed_floor) s = speed_floor;
        end else begin
          s = speed + SpeedInc;
        end
        if (s > speed_ceil) s = speed_ceil;
        if (mode == MODE_NONE) begin
          s = 0;
        end else begin
          vend = (mode == MODE_STRAIGHT) ? finish_speed : speed_floor;
          // braking distance at 1.5 m/s^2 in 2^-16 units
          if (!braking) begin
            if ((goal - trav) * 196608 < s * s - vend * vend) braking = 1'b1;
          end else if (trav > goal) begin
            running = 1'b0;
            s = 0;
          end
          if (mode == MODE_STRAIGHT) begin
            er = (sr > thresh_right) ? ref_right - sr : 0;
            el = (sl > thresh_left) ? sl - ref_left : 0;
            om = wall_gain * (er + el);
            vr = s + om;
            vl = s - om;
            if (vr < speed_floor) vr = speed_floor;
            if (vl < speed_floor) vl = speed_floor;
            lin = (vr + vl) / 2;
            if (lin > 65535) lin = 65535;
            ang = (vr - vl) * 500 / 47;
            if (ang > AngHi) ang = AngHi;
            if (ang < AngLo) ang = AngLo;
          end else begin
            ang = s * 250 / 47;
            if (mode == MODE_RIGHT) ang = -ang;
          end
        end
        speed = int'(s);
      end
      r.lin = lin[15:0];
      r.ang = ang[AngW-1:0];
      r.trav = it.trav;
      due_velocities.push_back(r);
    endfunction

    function void note_fault(string what, logic [63:0] want, logic [63:0] got);
      faults++;
      if (faults <= 10) $display("mismatch %s: expected %0h, got %0h", what, want, got);
    endfunction

    function void check_velocity(vel_t got);
      vel_t want;
      if (due_velocities.size() == 0) begin
        note_fault("unexpected result, travelled_echo", 64'd0, 64'(got.trav));
        return;
      end
      want = due_velocities.pop_front();
      if (got.lin !== want.lin) note_fault("linear_velocity", 64'(want.lin), 64'(got.lin));
      if (got.ang !== want.ang) note_fault("angular_velocity", 64'(want.ang), 64'(got.ang));
      if (got.fin !== want.fin) note_fault("finished", 64'(want.fin), 64'(got.fin));
      if (got.trav !== want.trav) note_fault("travelled_echo", 64'(want.trav), 64'(got.trav));
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic            kind_i = 1'b0;
  logic [23:0]     target_length_i = '0;
  logic [1:0]      mode_i = '0;
  logic [23:0]     travelled_i = '0;
  logic [11:0]     sensor_right_i = '0;
  logic [11:0]     sensor_left_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [15:0]     linear_velocity_o;
  logic [AngW-1:0] angular_velocity_o;
  logic            finished_o;
  logic [23:0]     travelled_echo_o;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [4:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;

  wheel_cmd_board board = new();
  bit calm = 1'b0;

  trapezoid_speed_profile_wall_follow_core uut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 11);
  end

  always @(posedge clk_i) begin
    vel_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.lin = linear_velocity_o;
      got.ang = angular_velocity_o;
      got.fin = finished_o;
      got.trav = travelled_echo_o;
      board.check_velocity(got);
    end
  end

  task automatic send(tick_t it);
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= it.kind;
    target_length_i <= it.target;
    mode_i          <= it.mode;
    travelled_i     <= it.trav;
    sensor_right_i  <= it.sr;
    sensor_left_i   <= it.sl;
    do @(posedge clk_i); while (in_stall_o);
    board.take_item(it);
  endtask

  // unused fields of each item carry junk
  task automatic send_tick(int trav, int sr, int sl);
    tick_t it;
    it.kind = 1'b0;
    it.target = 24'($urandom);
    it.mode = run_mode_e'($urandom_range(0, 3));
    it.trav = 24'(trav);
    it.sr = 12'(sr);
    it.sl = 12'(sl);
    send(it);
  endtask

  task automatic send_cmd(int target, run_mode_e m);
    tick_t it;
    it.kind = 1'b1;
    it.target = 24'(target);
    it.mode = m;
    it.trav = 24'($urandom);
    it.sr = 12'($urandom);
    it.sl = 12'($urandom);
    send(it);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    logic [31:0] data;
    data = val;
    if ($urandom_range(0, 1)) data[31:16] = 16'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_reg(idx, data);
  endtask

  task automatic load_setting(int ph);
    int unsigned v[8];
    case (ph)
      1: v = '{65535, 0, 0, 4095, 0, 0, 0, 1023};
      2: v = '{0, 0, 65535, 0, 4095, 4095, 4095, 0};
      3: v = '{65535, 65535, 65535, 2048, 2048, 1000, 1000, 512};
      default: begin
        v[0] = $urandom_range(6000, 40000);
        v[1] = $urandom_range(0, 6000);
        v[2] = $urandom_range(0, v[0]);
        // bits above the 12-bit field must be dropped
        v[3] = $urandom_range(600, 2000) | ($urandom_range(0, 15) << 12);
        v[4] = $urandom_range(300, 1500);
        v[5] = $urandom_range(0, 1200);
        v[6] = $urandom_range(0, 1200);
        v[7] = $urandom_range(0, 1023);
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(reg_idx_e'(i), v[i]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // commands give no result, so allow for one still in the pipe
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.due_velocities.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic int near_wall(int centre);
    int v;
    v = centre + int'($urandom_range(0, 600)) - 300;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  task automatic directed();
    send_tick(0, 0, 0);
    send_tick(24'hFFFFFF, 12'hFFF, 12'hFFF);
    // no mode ever chosen: run without end, speed held at zero
    send_cmd(100, MODE_NONE);
    send_tick(5, 1180, 570);
    send_tick(200, 4095, 0);
    send_cmd(24'hFFFFFF, MODE_STRAIGHT);
    send_tick(0, 4095, 4095);
    send_tick(10, 0, 0);
    send_tick(20, 301, 201);
    send_tick(30, 300, 200);
    send_tick(40, 1180, 570);
    // restart keeping straight mode and current speed, goal already passed
    send_cmd(0, MODE_NONE);
    send_tick(50, 1180, 570);
    send_tick(60, 1180, 570);
    send_tick(70, 1180, 570);
    send_cmd(40, MODE_RIGHT);
    send_tick(10, 0, 0);
    send_tick(100, 0, 0);
    send_tick(120, 0, 0);
    send_cmd(0, MODE_LEFT);
    send_tick(1, 0, 0);
    send_tick(100, 0, 0);
    send_tick(200, 0, 0);
    send_tick(300, 0, 0);
  endtask

  task automatic random_phase(int n);
    int unsigned r, mx, hi;
    int          run_ticks, pos;
    tick_t       it;
    run_ticks = 0;
    pos = 0;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 7) begin
        it.kind = 1'($urandom_range(0, 1));
        it.target = 24'($urandom);
        it.mode = run_mode_e'($urandom_range(0, 3));
        it.trav = 24'($urandom);
        it.sr = 12'($urandom);
        it.sl = 12'($urandom);
        send(it);
        if (it.kind) begin
          pos = 0;
          run_ticks = 0;
        end
      end else if (r < 10 || run_ticks >= 100 ||
                   (!board.running && $urandom_range(0, 3) != 0)) begin
        mx = board.speed_ceil;
        hi = 2 * (mx >> 8) * (mx >> 8) + 3000;
        send_cmd(($urandom_range(0, 19) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                               : $urandom_range(0, hi),
                 ($urandom_range(0, 9) == 0) ? MODE_NONE
                                             : run_mode_e'($urandom_range(0, 2)));
        pos = 0;
        run_ticks = 0;
      end else begin
        pos += (board.speed / 100) * $urandom_range(1, 6) + $urandom_range(0, 40);
        if (pos > 24'hFFFFFF) pos = 24'hFFFFFF;
        send_tick(pos,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                              : near_wall(board.ref_right),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                              : near_wall(board.ref_left));
        run_ticks++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    random_phase(130);
    for (int ph = 1; ph < 8; ph++) begin
      drain();
      calm = (ph == 2 || ph == 5);
      load_setting(ph);
      random_phase(160);
    end
    drain();
    if (board.faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(100_000 * 12);
    $display("tb: failure");
    $finish;
  end

endmodule

@@ trapezoid_speed_profile_wall_follow_core.f @@
rtl/core/tspwf_pkg.sv
rtl/core/tspwf_ang_scale.sv
rtl/core/trapezoid_speed_profile_wall_follow_core.sv
sim/tb_top.sv
